FILE: src/bdq_pkg.sv
package bdq_pkg;

    // Request opcodes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_REMOVE_AT  = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // What every cell of the row does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,      // keep contents
        CELL_SHIFT_UP,  // take the neighbour nearer the front
        CELL_APPEND,    // load the pushed value if this is the tail slot
        CELL_CLOSE      // at or after the gap: take the neighbour nearer the back
    } cell_cmd_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
        logic [3:0]  position;
    } req_t;

    typedef struct packed {
        logic [31:0] removed;
        logic [4:0]  count;
        logic [1:0]  status;
    } rsp_t;

endpackage

FILE: src/bdq_cell.sv
module bdq_cell #(
    parameter int ELEM_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  bdq_pkg::cell_cmd_t    cmd,
    input  logic [CNT_W-1:0]      at,
    input  logic [ELEM_WIDTH-1:0] value,
    input  logic [ELEM_WIDTH-1:0] left,
    input  logic [ELEM_WIDTH-1:0] right,
    output logic [ELEM_WIDTH-1:0] data
);
    import bdq_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd)
            CELL_HOLD:     data_next = data_reg;
            CELL_SHIFT_UP: data_next = left;
            CELL_APPEND:
            begin
                if (at == MY_IDX)
                    data_next = value;
            end
            CELL_CLOSE:
            begin
                if (MY_IDX >= at)
                    data_next = right;
            end
            default:       data_next = data_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: src/bounded_deque_with_indexed_remove.sv
// Bounded double-ended queue of up to DEPTH elements with removal at any
// position. Each request item (op, value, position) gives exactly one
// response item (removed, count, status), in order. Elements live in a row
// of DEPTH cells with the front in cell 0; every cycle each cell either
// holds, takes its front-side neighbour (push front), loads the pushed value
// (push back, tail cell only) or takes its back-side neighbour (pop front
// and remove-at, cells at or past the gap). One item is taken per clock
// while rsp_stall is low: the whole row moves in the cycle of acceptance and
// the response sits in an output register from the next cycle on, so the
// throughput is one item per cycle while rsp_stall is low. A response held
// under rsp_stall stalls req for as long as it waits. The removed element is
// read from the row with a single DEPTH-way select. Status: 0 ok, 1 empty on
// removal, 2 position at or beyond the count, 3 full on push; errors leave
// the store unchanged and give removed = 0. Clear empties the queue; opcodes
// 6 and 7 do nothing. count is the occupancy after the request, truncated to
// 5 bits; elements are ELEM_WIDTH bits, zero-extended or truncated to the
// 32-bit fields. Cell contents are undefined after reset; no clearing pass.
module bounded_deque_with_indexed_remove #(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bdq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bdq_pkg::rsp_t rsp
);
    import bdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    // occupancy and response register
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    // row of cells
    logic [ELEM_WIDTH-1:0] elem [DEPTH];
    logic [ELEM_WIDTH-1:0] push_val;
    cell_cmd_t             cmd;
    cell_cmd_t             cmd_req;
    logic [CNT_W-1:0]      at;
    logic [IDX_W-1:0]      rd_idx;
    logic [ELEM_WIDTH-1:0] rd_data;

    logic             accept;
    logic             full;
    logic             empty;
    logic             pos_bad;
    logic [1:0]       status;
    logic             take;       // this request removes an element
    logic [CNT_W-1:0] occ_after;

    // a held response blocks the next item
    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;

    assign push_val = ELEM_WIDTH'(req.value);
    assign full     = (occ_reg == FULL_CNT);
    assign empty    = (occ_reg == '0);
    assign pos_bad  = (CMP_W'(req.position) >= CMP_W'(occ_reg));

    // request decode
    always_comb
    begin
        cmd_req   = CELL_HOLD;
        at        = '0;
        rd_idx    = '0;
        status    = ST_OK;
        take      = 1'b0;
        occ_after = occ_reg;
        unique case (req.op)
            OP_PUSH_FRONT:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    cmd_req   = CELL_SHIFT_UP;
                    occ_after = occ_reg + ONE;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    cmd_req   = CELL_APPEND;
                    at        = occ_reg;
                    occ_after = occ_reg + ONE;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                    status = ST_EMPTY;
                else
                begin
                    cmd_req   = CELL_CLOSE;
                    take      = 1'b1;
                    occ_after = occ_reg - ONE;
                end
            end
            OP_POP_BACK:
            begin
                rd_idx = IDX_W'(occ_reg - ONE);
                if (empty)
                    status = ST_EMPTY;
                else
                begin
                    take      = 1'b1;
                    occ_after = occ_reg - ONE;
                end
            end
            OP_REMOVE_AT:
            begin
                rd_idx = IDX_W'(req.position);
                at     = CNT_W'(req.position);
                if (empty)
                    status = ST_EMPTY;
                else if (pos_bad)
                    status = ST_RANGE;
                else
                begin
                    cmd_req   = CELL_CLOSE;
                    take      = 1'b1;
                    occ_after = occ_reg - ONE;
                end
            end
            OP_CLEAR:
            begin
                occ_after = '0;
            end
            default:
            begin
                occ_after = occ_reg;
            end
        endcase
    end

    // the row only moves on an accepted item
    assign cmd = accept ? cmd_req : CELL_HOLD;

    assign rd_data = elem[rd_idx];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [ELEM_WIDTH-1:0] left_in;
            logic [ELEM_WIDTH-1:0] right_in;

            if (gi == 0)
            begin : g_head
                assign left_in = push_val;  // push front enters here
            end
            else
            begin : g_body
                assign left_in = elem[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_in = elem[gi];
            end
            else
            begin : g_inner
                assign right_in = elem[gi+1];
            end

            bdq_cell #(
                .ELEM_WIDTH (ELEM_WIDTH),
                .CNT_W      (CNT_W),
                .IDX        (gi)
            ) u_cell (
                .clk   (clk),
                .cmd   (cmd),
                .at    (at),
                .value (push_val),
                .left  (left_in),
                .right (right_in),
                .data  (elem[gi])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next       = accept ? occ_after : occ_reg;
        rsp_valid_next = accept | (rsp_valid_reg & rsp_stall);
        rsp_next       = rsp_reg;
        if (accept)
        begin
            rsp_next.removed = take ? 32'(rd_data) : '0;
            rsp_next.count   = 5'(occ_after);
            rsp_next.status  = status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // occupancy never passes the row length
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_CNT)
        else $error("occupancy beyond depth");

    // a rejected request leaves the store size alone
    a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (status != ST_OK) |=> occ_reg == $past(occ_reg))
        else $error("error request changed occupancy");

    // a pending response reports the live occupancy
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.count == 5'(occ_reg))
        else $error("response count out of step with occupancy");

    // no item taken while a response is held back
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("request taken over a held response");

    // the row is still unless an item is accepted
    a_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> cmd == CELL_HOLD)
        else $error("cells moved without an item");

endmodule
